// File: design/nla_pkg.sv
// ----------------------------------------------------------------------------
// nla_pkg
// Shared types and constants for the nearest landmark association core.
// ----------------------------------------------------------------------------
package nla_pkg;

  localparam int unsigned MAX_PREDICTED_DEF = 64;

  localparam int unsigned PosW  = 24;
  localparam int unsigned TagW  = 16;
  localparam int unsigned MagW  = PosW + 1;          // |a - b| of two PosW values
  localparam int unsigned SqW   = 2 * PosW + 1;      // (2^PosW)^2 fits in SqW bits
  localparam int unsigned DistW = SqW + 1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [TagW-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] sq_dist;
    logic [TagW-1:0]  tag;
  } dist_res_t;

endpackage

// File: design/nla_if.sv
// ----------------------------------------------------------------------------
// nla_req_if / nla_rsp_if
// Valid/ready channels for requests into and matches out of the core.
// ----------------------------------------------------------------------------
interface nla_req_if;
  import nla_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic [TagW-1:0]        landmark_id;

  modport source (output valid, req_type, pos_x, pos_y, landmark_id, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, landmark_id, output ready);
endinterface

interface nla_rsp_if;
  import nla_pkg::*;

  logic            valid;
  logic            ready;
  logic [TagW-1:0] match_id;
  logic            found;

  modport source (output valid, match_id, found, input ready);
  modport sink   (input valid, match_id, found, output ready);
endinterface

// File: design/nla_table.sv
// ----------------------------------------------------------------------------
// nla_table
// Landmark table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nla_table #(
  parameter int unsigned Depth = nla_pkg::MAX_PREDICTED_DEF,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  nla_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output nla_pkg::entry_t rd_data_o
);
  import nla_pkg::*;

  entry_t mem [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/nla_dist.sv
// ----------------------------------------------------------------------------
// nla_dist
// Shared squared-distance unit: abs difference, square, sum, one entry a cycle.
// ----------------------------------------------------------------------------
module nla_dist (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [nla_pkg::PosW-1:0] obs_x_i,
  input  logic signed [nla_pkg::PosW-1:0] obs_y_i,
  input  nla_pkg::entry_t                 entry_i,
  output nla_pkg::dist_res_t              res_o,
  output logic                            busy_o
);
  import nla_pkg::*;

  logic signed [MagW-1:0] diff_x, diff_y;
  logic [MagW-1:0]        mag_x, mag_y;
  logic [SqW-1:0]         prod_x, prod_y;

  logic                   valid_a_q, valid_b_q, valid_c_q;
  logic [MagW-1:0]        mag_x_a_q, mag_y_a_q;
  logic [TagW-1:0]        tag_a_q, tag_b_q, tag_c_q;
  logic [SqW-1:0]         sq_x_b_q, sq_y_b_q;
  logic [DistW-1:0]       dist_c_q;

  always_comb begin
    diff_x = MagW'(obs_x_i) - MagW'(entry_i.x);
    diff_y = MagW'(obs_y_i) - MagW'(entry_i.y);
    // the difference never reaches -2^PosW, so the negation cannot overflow
    mag_x  = diff_x[MagW-1] ? MagW'(-diff_x) : MagW'(diff_x);
    mag_y  = diff_y[MagW-1] ? MagW'(-diff_y) : MagW'(diff_y);
    prod_x = SqW'(mag_x_a_q) * SqW'(mag_x_a_q);
    prod_y = SqW'(mag_y_a_q) * SqW'(mag_y_a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_x_a_q <= mag_x;
    mag_y_a_q <= mag_y;
    tag_a_q   <= entry_i.tag;
    sq_x_b_q  <= prod_x;
    sq_y_b_q  <= prod_y;
    tag_b_q   <= tag_a_q;
    dist_c_q  <= DistW'(sq_x_b_q) + DistW'(sq_y_b_q);
    tag_c_q   <= tag_b_q;
  end

  assign res_o.valid   = valid_c_q;
  assign res_o.sq_dist = dist_c_q;
  assign res_o.tag     = tag_c_q;
  assign busy_o        = valid_a_q | valid_b_q | valid_c_q;

endmodule

// File: design/nearest_landmark_association_core.sv
// ----------------------------------------------------------------------------
// nearest_landmark_association_core
// Nearest-neighbor association of an observation against a landmark table.
// ----------------------------------------------------------------------------
// Clear and append words leave the core in idle, so request ready stays high.
// A query scans the table through one distance unit, one entry per cycle;
// each entry passes the table read, abs, square, sum and the compare, then the
// result is loaded; one query is in flight at a time.
// Reset empties the table (count to zero); entries need no clearing.
module nearest_landmark_association_core #(
  parameter int unsigned MAX_PREDICTED = nla_pkg::MAX_PREDICTED_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  nla_req_if.sink  req_i,
  nla_rsp_if.source rsp_o
);
  import nla_pkg::*;

  localparam int unsigned IdxW = (MAX_PREDICTED > 1) ? $clog2(MAX_PREDICTED) : 1;
  localparam int unsigned CntW = $clog2(MAX_PREDICTED + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PREDICTED);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic signed [PosW-1:0] obs_x_q, obs_y_q;
  logic              have_q;
  logic [DistW-1:0]  best_q;
  logic [TagW-1:0]   best_tag_q;
  logic              rd_valid_q;
  logic              out_valid_q;
  logic [TagW-1:0]   out_id_q;
  logic              out_found_q;

  logic              req_fire;
  req_type_e         req_type;
  logic              wr_en, rd_en, load_out, start_query;
  entry_t            wr_data, rd_data;
  dist_res_t         res;
  logic              dist_busy;

  assign req_type = req_type_e'(req_i.req_type);
  assign req_fire = req_i.valid & req_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (req_fire) begin
          unique case (req_type)
            REQ_CLEAR:  count_d = '0;
            REQ_APPEND: if (count_q < CntMax) count_d = count_q + 1'b1;
            REQ_QUERY:  state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
            default:    ;
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == count_q - 1'b1) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_valid_q && !dist_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    start_query = req_fire && (req_type == REQ_QUERY);
    wr_en       = req_fire && (req_type == REQ_APPEND) && (count_q < CntMax);
    rd_en       = (state_q == ST_SCAN);
    load_out    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  end

  assign wr_data.x   = req_i.pos_x;
  assign wr_data.y   = req_i.pos_y;
  assign wr_data.tag = req_i.landmark_id;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      rd_valid_q <= rd_en;
      if (start_query) begin
        have_q <= 1'b0;
      end else if (res.valid) begin
        have_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_query) begin
      obs_x_q <= req_i.pos_x;
      obs_y_q <= req_i.pos_y;
    end
    // strict less-than keeps the earliest entry on a tie
    if (res.valid && (!have_q || res.sq_dist < best_q)) begin
      best_q     <= res.sq_dist;
      best_tag_q <= res.tag;
    end
    if (load_out) begin
      out_id_q    <= have_q ? best_tag_q : '0;
      out_found_q <= have_q;
    end
  end

  nla_table #(
    .Depth (MAX_PREDICTED),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  nla_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_valid_q),
    .obs_x_i (obs_x_q),
    .obs_y_i (obs_y_q),
    .entry_i (rd_data),
    .res_o   (res),
    .busy_o  (dist_busy)
  );

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.match_id = out_id_q;
  assign rsp_o.found    = out_found_q;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nearest_landmark_association_core. Request words
// (clear, append, query and the unused code) are queued up front and driven
// with random gaps before the tail. Each accepted word updates a local landmark table. Each
// query also predicts its match by exact squared distance, with the earliest
// entry winning a tie. The response side stalls at random before the tail, and every match
// word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import nla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxEntries = MAX_PREDICTED_DEF;
  localparam int unsigned TailItems  = 300;
  localparam int unsigned RandItems  = 1800;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]             req_type;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [TagW-1:0]        landmark_id;
  } req_word_t;

  typedef struct packed {
    logic [TagW-1:0] match_id;
    logic            found;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nla_req_if req_if ();
  nla_rsp_if rsp_if ();

  nearest_landmark_association_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // local copy of the landmark table
  logic signed [PosW-1:0] tbl_x [MaxEntries];
  logic signed [PosW-1:0] tbl_y [MaxEntries];
  logic [TagW-1:0]        tbl_tag [MaxEntries];
  int unsigned            tbl_count = 0;

  req_word_t   pending_q[$];
  match_t      match_q[$];
  req_word_t   cur_word;
  match_t      want;
  int unsigned n_items = 0;
  int unsigned n_words = 0;
  int unsigned words_sent = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          can_load;
  bit          idle_on = 1'b1;

  // Update the table for one accepted word; queue the match a query produces.
  function automatic void associate_word(input req_word_t w);
    longint          best, d, dx, dy;
    logic [TagW-1:0] best_tag;
    bit              hit;
    match_t          m;
    case (w.req_type)
      REQ_CLEAR: tbl_count = 0;
      REQ_APPEND: begin
        if (tbl_count < MaxEntries) begin
          tbl_x[tbl_count]   = w.pos_x;
          tbl_y[tbl_count]   = w.pos_y;
          tbl_tag[tbl_count] = w.landmark_id;
          tbl_count++;
        end
      end
      REQ_QUERY: begin
        hit      = 1'b0;
        best     = 0;
        best_tag = '0;
        for (int i = 0; i < tbl_count; i++) begin
          dx = longint'(w.pos_x) - longint'(tbl_x[i]);
          dy = longint'(w.pos_y) - longint'(tbl_y[i]);
          d  = dx * dx + dy * dy;
          // strict compare keeps the earliest entry on a tie
          if (!hit || d < best) begin
            hit      = 1'b1;
            best     = d;
            best_tag = tbl_tag[i];
          end
        end
        m.match_id = best_tag;
        m.found    = hit;
        match_q.push_back(m);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [PosW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return PosMin;
      1:       return PosMax;
      2:       return PosW'($urandom_range(0, 2047)) - PosW'(1024);
      default: return PosW'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic signed [PosW-1:0] x,
                           input logic signed [PosW-1:0] y, input logic [TagW-1:0] tag);
    req_word_t w;
    w.req_type    = kind;
    w.pos_x       = x;
    w.pos_y       = y;
    w.landmark_id = tag;
    pending_q.push_back(w);
    if (kind != REQ_UNUSED) n_items++;
  endtask

  // One table build: optional clear, appends with queries and unused words mixed in, then queries.
  task automatic push_scenario();
    logic signed [PosW-1:0] cx, cy, x, y;
    logic signed [PosW-1:0] sx[$];
    logic signed [PosW-1:0] sy[$];
    int unsigned            fill, k, j, n_query;
    bit                     cluster;
    fill    = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
    cluster = $urandom_range(0, 1);
    cx      = rand_coord();
    cy      = rand_coord();
    if ($urandom_range(0, 7) != 0)
      push_word(REQ_CLEAR, rand_coord(), rand_coord(), TagW'($urandom));
    for (k = 0; k < fill; k++) begin
      if (sx.size() != 0 && $urandom_range(0, 9) == 0) begin
        // reuse a stored position under a fresh id to force a tie
        j = $urandom_range(0, sx.size() - 1);
        x = sx[j];
        y = sy[j];
      end else if (cluster) begin
        x = cx + PosW'($urandom_range(0, 1023)) - PosW'(512);
        y = cy + PosW'($urandom_range(0, 1023)) - PosW'(512);
      end else begin
        x = rand_coord();
        y = rand_coord();
      end
      sx.push_back(x);
      sy.push_back(y);
      push_word(REQ_APPEND, x, y, TagW'($urandom));
      if ($urandom_range(0, 5) == 0)
        push_word(REQ_QUERY, rand_coord(), rand_coord(), TagW'($urandom));
      if ($urandom_range(0, 29) == 0)
        push_word(REQ_UNUSED, rand_coord(), rand_coord(), TagW'($urandom));
    end
    n_query = $urandom_range(1, 6);
    for (k = 0; k < n_query; k++) begin
      if (sx.size() != 0 && $urandom_range(0, 2) != 0) begin
        j = $urandom_range(0, sx.size() - 1);
        x = sx[j] + PosW'($urandom_range(0, 63)) - PosW'(32);
        y = sy[j] + PosW'($urandom_range(0, 63)) - PosW'(32);
      end else begin
        x = rand_coord();
        y = rand_coord();
      end
      push_word(REQ_QUERY, x, y, TagW'($urandom));
    end
  endtask

  // Request driver: hold a word until accepted, then load the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        associate_word(cur_word);
        words_sent++;
        can_load = 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 3);
      end else begin
        can_load = !req_if.valid;
      end
      if (can_load) begin
        if (gap_left == 0 && pending_q.size() != 0) begin
          cur_word = pending_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.req_type    <= cur_word.req_type;
          req_if.pos_x       <= cur_word.pos_x;
          req_if.pos_y       <= cur_word.pos_y;
          req_if.landmark_id <= cur_word.landmark_id;
        end else begin
          if (gap_left != 0) gap_left--;
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Match monitor and response stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (match_q.size() == 0) begin
          $display("%0t: match word with none expected: match_id %h found %b",
                   $time, rsp_if.match_id, rsp_if.found);
          errors++;
        end else begin
          want = match_q.pop_front();
          if (rsp_if.match_id !== want.match_id) begin
            $display("%0t: match_id expected %h actual %h",
                     $time, want.match_id, rsp_if.match_id);
            errors++;
          end
          if (rsp_if.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, rsp_if.found);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned tail_from;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_CLEAR;
    req_if.pos_x       = '0;
    req_if.pos_y       = '0;
    req_if.landmark_id = '0;
    rsp_if.ready       = 1'b0;

    // directed: empty table, extremes, ties, overwrite after clear, unused code
    push_word(REQ_QUERY, PosMin, PosMax, 16'h0000);
    push_word(REQ_UNUSED, -1, -1, 16'hFFFF);
    push_word(REQ_CLEAR, 0, 0, 16'h0000);
    push_word(REQ_APPEND, PosMax, PosMax, 16'hFFFF);
    push_word(REQ_APPEND, PosMin, PosMin, 16'h0000);
    push_word(REQ_APPEND, 0, 0, 16'h1234);
    push_word(REQ_QUERY, PosMin, PosMin, 16'hFFFF);
    push_word(REQ_QUERY, PosMax, PosMax, 16'h0000);
    push_word(REQ_QUERY, PosMax, PosMin, 16'h0000);
    push_word(REQ_APPEND, 512, 0, 16'h00A5);
    push_word(REQ_QUERY, 256, 0, 16'h0000);
    push_word(REQ_APPEND, 0, 0, 16'hBEEF);
    push_word(REQ_QUERY, 0, 0, 16'h0000);
    push_word(REQ_QUERY, -1, -1, 16'h0000);
    push_word(REQ_CLEAR, PosMax, PosMin, 16'hFFFF);
    push_word(REQ_QUERY, 0, 0, 16'h0000);
    push_word(REQ_APPEND, -1, -1, 16'h5A5A);
    push_word(REQ_UNUSED, 0, 0, 16'h0000);
    push_word(REQ_QUERY, PosMax, PosMax, 16'h0000);
    push_word(REQ_QUERY, 300, -300, 16'h0000);
    push_word(REQ_CLEAR, 0, 0, 16'h0000);

    n_items = 0;
    while (n_items < RandItems - TailItems) push_scenario();
    tail_from = pending_q.size();
    while (n_items < RandItems) push_scenario();
    n_words = pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent < tail_from) @(posedge clk_i);
    idle_on = 1'b0;
    while (words_sent < n_words) @(posedge clk_i);
    while (match_q.size() != 0) @(posedge clk_i);
    // let any stray match word surface
    repeat (MaxEntries + 16) @(posedge clk_i);

    if (errors == 0) begin
      $display("nearest_landmark_association_core test passed");
    end else begin
      $display("nearest_landmark_association_core test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("nearest_landmark_association_core test failed");
    $finish;
  end

endmodule
